// ===== rtl/core/capb_pkg.sv =====
// ----------------------------------------------------------------------------
// capb_pkg
// Shared widths, mode codes and types for the capacitor bank balancer.
// ----------------------------------------------------------------------------
package capb_pkg;

    // field widths
    localparam int CELLS      = 4;
    localparam int IDX_W      = 2;
    localparam int MV_W       = 13;
    localparam int THR_W      = 10;
    localparam int SUM_W      = 15;
    localparam int MODE_W     = 3;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 13;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TARGET = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_THRESH = 1'd1;

    // register reset values
    localparam logic [MV_W-1:0]  TARGET_RST = 13'd0;
    localparam logic [THR_W-1:0] THRESH_RST = 10'd20;

    // controller mode codes
    localparam logic [MODE_W-1:0] MODE_INIT      = 3'd0;
    localparam logic [MODE_W-1:0] MODE_CHARGE    = 3'd1;
    localparam logic [MODE_W-1:0] MODE_BALANCE   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_MAINTAIN  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_DISCHARGE = 3'd4;

    // statistics from the merging stage
    typedef struct packed {
        logic [MV_W-1:0]  max_mv;
        logic [IDX_W-1:0] max_idx;
        logic [MV_W-1:0]  min_mv;
        logic [MV_W-1:0]  avg_mv;
    } stats_t;

    // controller decision for one item
    typedef struct packed {
        logic              charge_on;
        logic [CELLS-1:0]  bleed_mask;
        logic [MODE_W-1:0] next_mode;
    } decision_t;

endpackage

// ===== rtl/core/capacitor_bank_balancer.sv =====
// ----------------------------------------------------------------------------
// capacitor_bank_balancer
// Four-cell capacitor bank balancing controller, one sample set per transfer.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid / in_ready) carries four cell voltages in mV.
//   Each transfer yields one result on the output channel (out_valid /
//   out_ready): charge_on, bleed_mask and the mode after the step.
//   Four lanes test each cell against target plus threshold, a merging
//   stage forms max, min and average, and the controller picks the outputs.
//   The result sits in the output register the cycle after the input
//   transfer. Throughput is one item per cycle while the receiver does
//   not stall; the controller mode register updates on each input transfer.
//   When the receiver stalls, the output register holds its result and
//   in_ready stays low until the result is taken; a result taken in the
//   same cycle lets a new input transfer in.
//   Configuration writes (cfg_we, cfg_index, cfg_data) take effect at once.
//   Reset puts the controller in init, target to 0 and threshold to 20 mV,
//   and empties the output register.
// ----------------------------------------------------------------------------
module capacitor_bank_balancer (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [capb_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [capb_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [capb_pkg::MV_W-1:0]        cell0_mv,
    input  logic [capb_pkg::MV_W-1:0]        cell1_mv,
    input  logic [capb_pkg::MV_W-1:0]        cell2_mv,
    input  logic [capb_pkg::MV_W-1:0]        cell3_mv,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic                             charge_on,
    output logic [capb_pkg::CELLS-1:0]       bleed_mask,
    output logic [capb_pkg::MODE_W-1:0]      next_mode
);

    logic [capb_pkg::MV_W-1:0]   target_reg;
    logic [capb_pkg::THR_W-1:0]  thresh_reg;
    logic [capb_pkg::MODE_W-1:0] mode_reg;
    logic                        out_valid_reg;
    capb_pkg::decision_t         result_reg;

    logic [capb_pkg::CELLS-1:0][capb_pkg::MV_W-1:0] cells;
    logic [capb_pkg::CELLS-1:0]  over;
    capb_pkg::stats_t            stats;
    capb_pkg::decision_t         decision;
    logic                        in_xfer;
    logic                        out_valid_next;

    assign cells = {cell3_mv, cell2_mv, cell1_mv, cell0_mv};

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg <= capb_pkg::TARGET_RST;
            thresh_reg <= capb_pkg::THRESH_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                capb_pkg::REG_TARGET: target_reg <= cfg_data;
                capb_pkg::REG_THRESH: thresh_reg <= cfg_data[capb_pkg::THR_W-1:0];
                default: ;
            endcase
        end
    end

    // per-cell lanes
    for (genvar g = 0; g < capb_pkg::CELLS; g++)
    begin : g_lane
        capb_lane u_lane (
            .cell_mv             (cells[g]),
            .target_mv           (target_reg),
            .spread_threshold_mv (thresh_reg),
            .over                (over[g])
        );
    end

    // merging stage
    capb_merge u_merge (
        .cells (cells),
        .stats (stats)
    );

    // mode controller
    capb_ctrl u_ctrl (
        .mode                (mode_reg),
        .stats               (stats),
        .over                (over),
        .target_mv           (target_reg),
        .spread_threshold_mv (thresh_reg),
        .decision            (decision)
    );

    // handshake
    assign in_ready       = !out_valid_reg || out_ready;
    assign in_xfer        = in_valid && in_ready;
    assign out_valid_next = in_xfer || (out_valid_reg && !out_ready);

    // mode and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= capb_pkg::MODE_INIT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (in_xfer)
                mode_reg <= decision.next_mode;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (in_xfer)
            result_reg <= decision;
    end

    assign out_valid  = out_valid_reg;
    assign charge_on  = result_reg.charge_on;
    assign bleed_mask = result_reg.bleed_mask;
    assign next_mode  = result_reg.next_mode;

endmodule

// ===== rtl/core/capb_lane.sv =====
// ----------------------------------------------------------------------------
// capb_lane
// Per-cell lane: flags a cell that sits above target plus threshold.
// ----------------------------------------------------------------------------
module capb_lane (
    input  logic [capb_pkg::MV_W-1:0]  cell_mv,
    input  logic [capb_pkg::MV_W-1:0]  target_mv,
    input  logic [capb_pkg::THR_W-1:0] spread_threshold_mv,
    output logic                       over
);

    logic [capb_pkg::MV_W:0] limit;

    // overshoot limit, one bit wider so it cannot wrap
    assign limit = {1'b0, target_mv} + {{(capb_pkg::MV_W-capb_pkg::THR_W+1){1'b0}},
                                        spread_threshold_mv};

    // at or above target and beyond it by more than the threshold
    assign over = {1'b0, cell_mv} > limit;

endmodule

// ===== rtl/core/capb_merge.sv =====
// ----------------------------------------------------------------------------
// capb_merge
// Merging stage: maximum with first index, minimum and truncated average.
// ----------------------------------------------------------------------------
module capb_merge (
    input  logic [capb_pkg::CELLS-1:0][capb_pkg::MV_W-1:0] cells,
    output capb_pkg::stats_t                               stats
);

    logic [capb_pkg::MV_W-1:0]  max_a, max_b, min_a, min_b;
    logic [capb_pkg::IDX_W-1:0] idx_a, idx_b;
    logic [capb_pkg::SUM_W-1:0] sum;

    // first level of the tree, lower index wins on a tie
    always_comb
    begin
        if (cells[1] > cells[0])
        begin
            max_a = cells[1];
            idx_a = 2'd1;
        end
        else
        begin
            max_a = cells[0];
            idx_a = 2'd0;
        end
        if (cells[3] > cells[2])
        begin
            max_b = cells[3];
            idx_b = 2'd3;
        end
        else
        begin
            max_b = cells[2];
            idx_b = 2'd2;
        end
        min_a = (cells[1] < cells[0]) ? cells[1] : cells[0];
        min_b = (cells[3] < cells[2]) ? cells[3] : cells[2];
    end

    // second level and the sum
    always_comb
    begin
        if (max_b > max_a)
        begin
            stats.max_mv  = max_b;
            stats.max_idx = idx_b;
        end
        else
        begin
            stats.max_mv  = max_a;
            stats.max_idx = idx_a;
        end
        stats.min_mv = (min_b < min_a) ? min_b : min_a;
        sum = {2'b00, cells[0]} + {2'b00, cells[1]}
            + {2'b00, cells[2]} + {2'b00, cells[3]};
        stats.avg_mv = sum[capb_pkg::SUM_W-1:capb_pkg::IDX_W];
    end

endmodule

// ===== rtl/core/capb_ctrl.sv =====
// ----------------------------------------------------------------------------
// capb_ctrl
// Mode controller: charge switch, bleed flags and next mode from the stats.
// ----------------------------------------------------------------------------
module capb_ctrl (
    input  logic [capb_pkg::MODE_W-1:0] mode,
    input  capb_pkg::stats_t            stats,
    input  logic [capb_pkg::CELLS-1:0]  over,
    input  logic [capb_pkg::MV_W-1:0]   target_mv,
    input  logic [capb_pkg::THR_W-1:0]  spread_threshold_mv,
    output capb_pkg::decision_t         decision
);

    logic [16:0]               avg_x10, tgt_x3;
    logic [15:0]               max_x5, tgt_x4;
    logic [capb_pkg::MV_W-1:0] spread;
    logic                      spread_hit;
    logic [capb_pkg::CELLS-1:0] max_onehot;

    // exact fraction compares by cross-multiplication
    assign avg_x10 = ({4'd0, stats.avg_mv} << 3) + ({4'd0, stats.avg_mv} << 1);
    assign tgt_x3  = ({4'd0, target_mv} << 1) + {4'd0, target_mv};
    assign max_x5  = ({3'd0, stats.max_mv} << 2) + {3'd0, stats.max_mv};
    assign tgt_x4  = {3'd0, target_mv} << 2;

    // spread test and the bleed flag for the highest cell
    assign spread     = stats.max_mv - stats.min_mv;
    assign spread_hit = spread > {{(capb_pkg::MV_W-capb_pkg::THR_W){1'b0}},
                                  spread_threshold_mv};
    assign max_onehot = capb_pkg::CELLS'(1) << stats.max_idx;

    // mode decisions
    always_comb
    begin
        decision.charge_on  = 1'b0;
        decision.bleed_mask = '0;
        decision.next_mode  = mode;
        unique case (mode)
            capb_pkg::MODE_CHARGE:
            begin
                decision.charge_on = 1'b1;
                if (avg_x10 > tgt_x3)
                    decision.next_mode = capb_pkg::MODE_BALANCE;
            end
            capb_pkg::MODE_BALANCE:
            begin
                decision.charge_on = 1'b1;
                if (spread_hit)
                    decision.bleed_mask = max_onehot;
                if (stats.avg_mv > target_mv)
                    decision.next_mode = capb_pkg::MODE_MAINTAIN;
                else if (max_x5 < tgt_x4)
                    decision.next_mode = capb_pkg::MODE_CHARGE;
            end
            capb_pkg::MODE_MAINTAIN:
            begin
                if (spread_hit)
                    decision.bleed_mask = max_onehot;
                if (stats.min_mv > target_mv)
                    decision.next_mode = capb_pkg::MODE_DISCHARGE;
                else if (stats.max_mv < target_mv)
                    decision.next_mode = capb_pkg::MODE_BALANCE;
            end
            capb_pkg::MODE_DISCHARGE:
            begin
                decision.bleed_mask = over;
                if (over == '0)
                    decision.next_mode = capb_pkg::MODE_MAINTAIN;
            end
            // init and the unused codes
            default:
            begin
                decision.next_mode = capb_pkg::MODE_CHARGE;
            end
        endcase
    end

endmodule

// ===== tb/capacitor_bank_balancer_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// capacitor_bank_balancer_test
// Drives four-cell voltage sets through the balancer with random idle gaps on
// the input side and random stalls on the result side. A local copy of the
// five-state controller predicts charge, bleed and next mode for every input
// transfer, and each result transfer is checked against the oldest prediction.
// Settings of target and threshold change only while the block is drained.
// ----------------------------------------------------------------------------
module capacitor_bank_balancer_test;

    typedef logic [capb_pkg::CELLS-1:0][capb_pkg::MV_W-1:0] cell_set_t;

    // voltage regimes for random sets, relative to the current target
    typedef enum int {LVL_NOISE, LVL_LOW, LVL_MID, LVL_TARGET, LVL_ABOVE} level_t;

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            cfg_we = 1'b0;
    logic [capb_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [capb_pkg::CFG_DATA_W-1:0] cfg_data = '0;
    logic                            in_valid = 1'b0;
    logic                            in_ready;
    logic [capb_pkg::MV_W-1:0]       cell0_mv = '0;
    logic [capb_pkg::MV_W-1:0]       cell1_mv = '0;
    logic [capb_pkg::MV_W-1:0]       cell2_mv = '0;
    logic [capb_pkg::MV_W-1:0]       cell3_mv = '0;
    logic                            out_valid;
    logic                            out_ready = 1'b0;
    logic                            charge_on;
    logic [capb_pkg::CELLS-1:0]      bleed_mask;
    logic [capb_pkg::MODE_W-1:0]     next_mode;

    // controller copy used for prediction
    logic [capb_pkg::MODE_W-1:0]     ctl_mode = capb_pkg::MODE_INIT;
    logic [capb_pkg::MV_W-1:0]       ctl_target = capb_pkg::TARGET_RST;
    logic [capb_pkg::THR_W-1:0]      ctl_thresh = capb_pkg::THRESH_RST;

    cell_set_t                       pending_sets[$];
    capb_pkg::decision_t             expected_decisions[$];
    logic                            in_taken = 1'b0;
    logic                            quiet_phase = 1'b0;
    int                              send_gap = 0;
    int                              stall_left = 0;
    int                              mismatches = 0;

    capacitor_bank_balancer u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .cell0_mv   (cell0_mv),
        .cell1_mv   (cell1_mv),
        .cell2_mv   (cell2_mv),
        .cell3_mv   (cell3_mv),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .charge_on  (charge_on),
        .bleed_mask (bleed_mask),
        .next_mode  (next_mode)
    );

    always #10 clk = ~clk;

    // idle length: mostly short, now and then long
    function automatic int pick_gap();
        if ($urandom_range(0, 9) < 8)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [capb_pkg::MV_W-1:0] clamp_mv(input int x);
        if (x < 0)
        begin
            return '0;
        end
        if (x > 8191)
        begin
            return 13'd8191;
        end
        return x[capb_pkg::MV_W-1:0];
    endfunction

    // controller decision for one set, from the current mode and settings
    function automatic capb_pkg::decision_t balance_decision(input cell_set_t s);
        capb_pkg::decision_t d;
        int                  hi;
        int                  lo;
        int                  sum;
        int                  avg;
        int                  hi_idx;
        int                  v;
        int                  i;
        int                  t;
        int                  th;
        hi = 0;
        lo = 8191;
        sum = 0;
        hi_idx = 0;
        t = ctl_target;
        th = ctl_thresh;
        for (i = 0; i < capb_pkg::CELLS; i++)
        begin
            v = s[i];
            if (v > hi)
            begin
                hi = v;
                hi_idx = i;
            end
            if (v < lo)
            begin
                lo = v;
            end
            sum += v;
        end
        avg = sum / capb_pkg::CELLS;
        d.charge_on = 1'b0;
        d.bleed_mask = '0;
        d.next_mode = ctl_mode;
        case (ctl_mode)
            capb_pkg::MODE_CHARGE:
            begin
                d.charge_on = 1'b1;
                if (10 * avg > 3 * t)
                begin
                    d.next_mode = capb_pkg::MODE_BALANCE;
                end
            end
            capb_pkg::MODE_BALANCE:
            begin
                d.charge_on = 1'b1;
                if (hi - lo > th)
                begin
                    d.bleed_mask[hi_idx] = 1'b1;
                end
                if (5 * hi < 4 * t)
                begin
                    d.next_mode = capb_pkg::MODE_CHARGE;
                end
                if (avg > t)
                begin
                    d.next_mode = capb_pkg::MODE_MAINTAIN;
                end
            end
            capb_pkg::MODE_MAINTAIN:
            begin
                if (hi - lo > th)
                begin
                    d.bleed_mask[hi_idx] = 1'b1;
                end
                if (hi < t)
                begin
                    d.next_mode = capb_pkg::MODE_BALANCE;
                end
                if (lo > t)
                begin
                    d.next_mode = capb_pkg::MODE_DISCHARGE;
                end
            end
            capb_pkg::MODE_DISCHARGE:
            begin
                for (i = 0; i < capb_pkg::CELLS; i++)
                begin
                    v = s[i];
                    if (v >= t && v - t > th)
                    begin
                        d.bleed_mask[i] = 1'b1;
                    end
                end
                if (d.bleed_mask == '0)
                begin
                    d.next_mode = capb_pkg::MODE_MAINTAIN;
                end
            end
            default:
            begin
                // init and the unused codes
                d.next_mode = capb_pkg::MODE_CHARGE;
            end
        endcase
        return d;
    endfunction

    // random set around one voltage regime
    function automatic cell_set_t make_cell_set(input level_t lvl);
        cell_set_t s;
        int        base;
        int        jitter;
        int        t;
        int        th;
        int        i;
        int        k;
        t = ctl_target;
        th = ctl_thresh;
        case (lvl)
            LVL_LOW:    base = int'($urandom_range(0, t * 3 / 10 + 2));
            LVL_MID:    base = int'($urandom_range(t * 3 / 10, t));
            LVL_TARGET: base = t - th - 4 + int'($urandom_range(0, 2 * th + 8));
            LVL_ABOVE:  base = t + 1 + int'($urandom_range(0, 2 * th + 50));
            default:    base = 0;
        endcase
        jitter = th + 4;
        for (i = 0; i < capb_pkg::CELLS; i++)
        begin
            if (lvl == LVL_NOISE)
            begin
                s[i] = capb_pkg::MV_W'($urandom_range(0, 8191));
            end
            else
            begin
                s[i] = clamp_mv(base - jitter + int'($urandom_range(0, 2 * jitter)));
            end
        end
        // occasional tie: a cell takes the value of an earlier cell
        if ($urandom_range(0, 9) == 0)
        begin
            k = $urandom_range(1, capb_pkg::CELLS - 1);
            s[k] = s[$urandom_range(0, k - 1)];
        end
        return s;
    endfunction

    function automatic void push_cells(input int c0, input int c1, input int c2, input int c3);
        pending_sets.push_back({clamp_mv(c3), clamp_mv(c2), clamp_mv(c1), clamp_mv(c0)});
    endfunction

    task automatic write_reg(input logic [capb_pkg::CFG_IDX_W-1:0] idx, input int val);
        logic [capb_pkg::CFG_DATA_W-1:0] word;
        word = val[capb_pkg::CFG_DATA_W-1:0];
        // threshold register keeps the low bits only, so dirty the top ones
        if (idx == capb_pkg::REG_THRESH)
        begin
            word[capb_pkg::CFG_DATA_W-1:capb_pkg::THR_W] = 3'($urandom_range(0, 7));
        end
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= word;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == capb_pkg::REG_TARGET)
        begin
            ctl_target = word[capb_pkg::MV_W-1:0];
        end
        else
        begin
            ctl_thresh = word[capb_pkg::THR_W-1:0];
        end
    endtask

    // hold off until every queued set went in and every result came out
    task automatic wait_drained();
        while (pending_sets.size() != 0 || in_valid || expected_decisions.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (2) @(posedge clk);
    endtask

    task automatic start_phase(input int target, input int thresh);
        wait_drained();
        write_reg(capb_pkg::REG_TARGET, target);
        write_reg(capb_pkg::REG_THRESH, thresh);
        quiet_phase = ($urandom_range(0, 3) == 0);
    endtask

    // input driver
    always @(negedge clk)
    begin
        cell_set_t s;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else if (!in_valid || in_taken)
        begin
            if (send_gap > 0)
            begin
                send_gap <= send_gap - 1;
                in_valid <= 1'b0;
            end
            else if (pending_sets.size() != 0)
            begin
                s = pending_sets.pop_front();
                in_valid <= 1'b1;
                cell0_mv <= s[0];
                cell1_mv <= s[1];
                cell2_mv <= s[2];
                cell3_mv <= s[3];
                if (quiet_phase || $urandom_range(0, 1) == 0)
                begin
                    send_gap <= 0;
                end
                else
                begin
                    send_gap <= pick_gap();
                end
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // result-side stalls
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            out_ready <= 1'b0;
        end
        else if (quiet_phase || $urandom_range(0, 9) < 7)
        begin
            out_ready <= 1'b1;
        end
        else
        begin
            stall_left <= pick_gap() - 1;
            out_ready <= 1'b0;
        end
    end

    // result check, then prediction for the input transfer
    always @(posedge clk)
    begin
        capb_pkg::decision_t want;
        if (!rst_n)
        begin
            in_taken <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_decisions.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("%0t: result with nothing expected: charge %0d bleed %b mode %0d",
                                 $realtime, charge_on, bleed_mask, next_mode);
                    end
                end
                else
                begin
                    want = expected_decisions.pop_front();
                    if (charge_on !== want.charge_on || bleed_mask !== want.bleed_mask
                        || next_mode !== want.next_mode)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                        begin
                            $display("%0t: expected charge %0d bleed %b mode %0d, got %0d %b %0d",
                                     $realtime, want.charge_on, want.bleed_mask,
                                     want.next_mode, charge_on, bleed_mask, next_mode);
                        end
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                want = balance_decision({cell3_mv, cell2_mv, cell1_mv, cell0_mv});
                ctl_mode = want.next_mode;
                expected_decisions.push_back(want);
            end
            in_taken <= in_valid && in_ready;
        end
    end

    // stimulus
    initial
    begin
        int     p;
        int     count;
        int     run;
        int     target;
        int     thresh;
        int     r;
        int     wait_cycles;
        level_t lvl;

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // tour of all modes with the settings left by reset
        push_cells(0, 0, 0, 0);
        push_cells(0, 0, 0, 0);
        push_cells(8191, 8191, 8191, 8191);
        push_cells(8191, 0, 8191, 0);
        push_cells(0, 8191, 8191, 0);
        push_cells(30, 21, 20, 8191);
        push_cells(21, 20, 0, 8191);
        push_cells(20, 20, 20, 20);

        // boundaries of each compare around a 4000 mV target
        start_phase(4000, 20);
        push_cells(3000, 3000, 3000, 3000);
        push_cells(3000, 3040, 3000, 3010);
        push_cells(1200, 1200, 1200, 1200);
        push_cells(1201, 1201, 1201, 1201);
        push_cells(3200, 3200, 3200, 3200);
        push_cells(4001, 4001, 4001, 4001);
        push_cells(4000, 4001, 4001, 4001);
        push_cells(4021, 4021, 4030, 4021);
        push_cells(4020, 4021, 3999, 8191);
        push_cells(4020, 4020, 4020, 4020);

        // random phases, extremes of both registers first
        for (p = 0; p < 10; p++)
        begin
            case (p)
                0:
                begin
                    target = 8191;
                    thresh = 1023;
                end
                1:
                begin
                    target = 0;
                    thresh = 0;
                end
                2:
                begin
                    target = 8191;
                    thresh = 0;
                end
                default:
                begin
                    target = $urandom_range(0, 8191);
                    r = $urandom_range(0, 3);
                    thresh = (r == 0) ? 0 : (r == 1) ? 1023 : int'($urandom_range(0, 150));
                end
            endcase
            start_phase(target, thresh);
            count = 0;
            while (count < 48)
            begin
                if ($urandom_range(0, 9) == 0)
                begin
                    lvl = LVL_NOISE;
                end
                else
                begin
                    lvl = level_t'($urandom_range(1, 4));
                end
                // runs of one regime let the controller settle into a mode
                for (run = $urandom_range(1, 8); run > 0 && count < 48; run--)
                begin
                    pending_sets.push_back(make_cell_set(lvl));
                    count++;
                end
            end
        end

        // drain, bounded
        wait_cycles = 0;
        while (wait_cycles < 100000
               && (pending_sets.size() != 0 || in_valid || expected_decisions.size() != 0))
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (4) @(posedge clk);
        if (pending_sets.size() != 0 || expected_decisions.size() != 0)
        begin
            mismatches++;
            $display("results still missing at the end: %0d", expected_decisions.size());
        end

        if (mismatches == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // run limit
    initial
    begin
        #20_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
